@@ rtl/sswq_pkg.sv @@
// package for the sorted sleep/wakeup queue
// types, field widths and result codes shared by the interfaces and modules
package sswq_pkg;

    localparam int SSWQ_DEPTH_DEF = 16;
    localparam int ID_W           = 8;
    localparam int TICKS_W        = 32;
    localparam int TIME_W         = 64;
    localparam int KIND_W         = 2;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_WOKEN    = 2'd2
    } t_kind;

    // one table slot: wake time and owner
    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } t_entry;

endpackage

@@ rtl/sswq_if.sv @@
// request and result channels of the sorted sleep/wakeup queue
// depends on sswq_pkg for the field widths, including the result kind width
interface sswq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [sswq_pkg::ID_W-1:0]    waiter_id;
    logic [sswq_pkg::TICKS_W-1:0] sleep_ticks;

    modport source (output valid, operation, waiter_id, sleep_ticks, input ready);
    modport sink   (input valid, operation, waiter_id, sleep_ticks, output ready);
endinterface

interface sswq_res_if;
    logic                        valid;
    logic                        ready;
    logic [sswq_pkg::KIND_W-1:0] kind;
    logic [sswq_pkg::ID_W-1:0]   woken_id;
    logic                        last;

    modport source (output valid, kind, woken_id, last, input ready);
    modport sink   (input valid, kind, woken_id, last, output ready);
endinterface

@@ rtl/sswq_mem.sv @@
// waiter table storage: one write port, one read port, registered read data
// depends on sswq_pkg for the entry type
module sswq_mem #(
    parameter int DEPTH = sswq_pkg::SSWQ_DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IW-1:0]       i_waddr,
    input  sswq_pkg::t_entry    i_wdata,
    input  logic [IW-1:0]       i_raddr,
    output sswq_pkg::t_entry    o_rdata
);
    import sswq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sorted_sleep_wakeup_queue_unit.sv @@
// sorted sleep/wakeup queue: tick counter, table controller and result register
// depends on sswq_pkg, sswq_if (request and result channels) and sswq_mem
//
//   channel  dir  beat contents
//   i_req    in   operation, waiter_id, sleep_ticks
//   o_res    out  kind, woken_id, last
//
// the table is a ring in sswq_mem with a single read port; inserts and releases walk it
// sleep: walks back from the tail past every waiter whose wake time is later than the new one
// tick: no walk on an empty table and no result when nothing is due; else the due waiters
//   are released from the head, one result each, with last set on the final one
// full reject answers from idle without a walk; a stalled o_res holds the release walk, i_req waits for idle
// reset (synchronous, i_rst_n low) empties the table and zeroes the tick count
module sorted_sleep_wakeup_queue_unit #(
    parameter int QUEUE_DEPTH = sswq_pkg::SSWQ_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sswq_req_if.sink  i_req,
    sswq_res_if.source o_res
);
    import sswq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS   = 4'b0010,
        S_REL   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_tick, n_tick;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_occ, n_occ;
    logic [CW-1:0]       r_pos, n_pos;
    logic [TIME_W-1:0]   r_wake, n_wake;
    logic [ID_W-1:0]     r_id, n_id;
    logic                r_have_pend, n_have_pend;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic                r_o_valid, n_o_valid;
    t_kind               r_o_kind, n_o_kind;
    logic [ID_W-1:0]     r_o_id, n_o_id;
    logic                r_o_last, n_o_last;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic [IW-1:0]       mem_raddr;
    t_entry              mem_rdata;
    logic                out_free;
    logic                in_acc;
    logic                due;
    logic [CW-1:0]       rd_off;

    // ring position of logical slot off, counted from base
    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign out_free    = !r_o_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_req.valid && i_req.ready;
    assign due         = mem_rdata.wake <= r_tick;

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_head      = r_head;
        n_occ       = r_occ;
        n_pos       = r_pos;
        n_wake      = r_wake;
        n_id        = r_id;
        n_have_pend = r_have_pend;
        n_pend_id   = r_pend_id;
        n_o_valid   = r_o_valid && !o_res.ready;
        n_o_kind    = r_o_kind;
        n_o_id      = r_o_id;
        n_o_last    = r_o_last;
        mem_we      = 1'b0;
        mem_waddr   = f_phys(r_head, r_pos);
        mem_wdata   = mem_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (t_op'(i_req.operation) == OP_TICK) begin
                        n_tick = r_tick + TIME_W'(1);
                        if (r_occ != '0) begin
                            n_state = S_REL;
                        end
                    end else if (r_occ == CW'(QUEUE_DEPTH)) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_FULL;
                        n_o_id    = i_req.waiter_id;
                        n_o_last  = 1'b1;
                    end else begin
                        // answer at once; the table walk finishes before the next beat
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_ACCEPTED;
                        n_o_id    = i_req.waiter_id;
                        n_o_last  = 1'b1;
                        n_wake    = r_tick + TIME_W'(i_req.sleep_ticks);
                        n_id      = i_req.waiter_id;
                        n_pos     = r_occ;
                        n_state   = S_INS;
                    end
                end
            end
            S_INS: begin
                // walk back from the tail, moving later waiters up one slot
                mem_we = 1'b1;
                if (r_pos == '0 || mem_rdata.wake <= r_wake) begin
                    mem_wdata.wake = r_wake;
                    mem_wdata.id   = r_id;
                    n_occ          = r_occ + CW'(1);
                    n_state        = S_IDLE;
                end else begin
                    n_pos = r_pos - CW'(1);
                end
            end
            S_REL: begin
                if (due) begin
                    if (!r_have_pend || out_free) begin
                        if (r_have_pend) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = KIND_WOKEN;
                            n_o_id    = r_pend_id;
                            n_o_last  = 1'b0;
                        end
                        n_pend_id   = mem_rdata.id;
                        n_have_pend = 1'b1;
                        n_head      = f_phys(r_head, CW'(1));
                        n_occ       = r_occ - CW'(1);
                        if (r_occ == CW'(1)) begin
                            n_state = S_FLUSH;
                        end
                    end
                end else if (r_have_pend) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = KIND_WOKEN;
                    n_o_id      = r_pend_id;
                    n_o_last    = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // insert reads the slot below the next write; otherwise the read follows the head
    assign rd_off    = (n_pos == '0) ? '0 : n_pos - CW'(1);
    assign mem_raddr = (n_state == S_INS) ? f_phys(r_head, rd_off) : n_head;

    sswq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_head      <= '0;
            r_occ       <= '0;
            r_have_pend <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_have_pend <= n_have_pend;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_wake    <= n_wake;
        r_id      <= n_id;
        r_pend_id <= n_pend_id;
        r_o_kind  <= n_o_kind;
        r_o_id    <= n_o_id;
        r_o_last  <= n_o_last;
    end

    assign o_res.valid    = r_o_valid;
    assign o_res.kind     = r_o_kind;
    assign o_res.woken_id = r_o_id;
    assign o_res.last     = r_o_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("table occupancy above depth");

    a_wr_in_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_INS))
        else $error("table write outside insert walk");

    a_ins_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_pos <= r_occ && r_occ < CW'(QUEUE_DEPTH)))
        else $error("insert position out of range");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_have_pend)
        else $error("flush without a pending release");

    a_tick_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && t_op'(i_req.operation) == OP_TICK) |=> (r_tick == $past(r_tick) + TIME_W'(1)))
        else $error("tick count did not advance");

endmodule

@@ verif/sswq_wake_checker.sv @@
// scoreboard for the sorted sleep/wakeup queue: watches the request and result channels,
// keeps its own copy of the waiter table and tick count, compares every result beat
// depends on sswq_pkg and the sswq_req_if / sswq_res_if interfaces
module sswq_wake_checker #(
    parameter int QUEUE_DEPTH = sswq_pkg::SSWQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sswq_req_if  req,
    sswq_res_if  res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import sswq_pkg::*;

    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_wake_result;

    t_entry            sleepers[$];   // sorted by wake time, earliest first
    t_wake_result      awaited[$];    // results not yet seen on o_res
    logic [TIME_W-1:0] now_ticks;
    int                fails;
    int                checked;

    function automatic void push_result(t_kind kind, logic [ID_W-1:0] id, logic last);
        t_wake_result r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        awaited.push_back(r);
    endfunction

    function automatic void predict_sleep(logic [ID_W-1:0] id, logic [TICKS_W-1:0] ticks);
        logic [TIME_W-1:0] wake;
        int                pos;
        t_entry            e;
        if (sleepers.size() >= QUEUE_DEPTH) begin
            push_result(KIND_FULL, id, 1'b1);
            return;
        end
        wake = now_ticks + TIME_W'(ticks);
        pos  = 0;
        // equal wake times keep arrival order
        while (pos < sleepers.size() && sleepers[pos].wake <= wake)
            pos++;
        e.wake = wake;
        e.id   = id;
        sleepers.insert(pos, e);
        push_result(KIND_ACCEPTED, id, 1'b1);
    endfunction

    function automatic void predict_tick();
        int due;
        now_ticks = now_ticks + 1;
        due = 0;
        while (due < sleepers.size() && sleepers[due].wake <= now_ticks)
            due++;
        for (int i = 0; i < due; i++) begin
            push_result(KIND_WOKEN, sleepers[0].id, (i == due - 1));
            void'(sleepers.pop_front());
        end
    endfunction

    always @(posedge i_clk) begin
        t_wake_result exp_r;
        if (!i_rst_n) begin
            sleepers.delete();
            awaited.delete();
            now_ticks = '0;
            fails     = 0;
            checked   = 0;
        end else begin
            // result beat first: it always belongs to an earlier request
            if (res.valid && res.ready) begin
                checked++;
                if (awaited.size() == 0) begin
                    $error("unexpected result beat: kind %0d id %0d last %0d",
                           res.kind, res.woken_id, res.last);
                    fails++;
                end else begin
                    exp_r = awaited.pop_front();
                    if (res.kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, res.kind);
                        fails++;
                    end
                    if (res.woken_id !== exp_r.id) begin
                        $error("woken_id: expected %0d, got %0d", exp_r.id, res.woken_id);
                        fails++;
                    end
                    if (res.last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, res.last);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                if (req.operation == OP_TICK)
                    predict_tick();
                else
                    predict_sleep(req.waiter_id, req.sleep_ticks);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited.size();
        o_checked    <= checked;
    end

endmodule

@@ verif/tb.sv @@
// top of the sorted sleep/wakeup queue testbench: clock, reset, request stimulus,
// result back-pressure and the verdict; checking is done by sswq_wake_checker
// depends on sswq_pkg, the sswq interfaces, the checker and the unit itself
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sswq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int ITEM_GOAL    = 146;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sleeps_sent    = 0;
    int ticks_sent     = 0;
    int quiet_cycles   = 0;
    int long_sleeps    = 0;
    int fail_count;
    int pending;
    int checked;

    sswq_req_if req_ch ();
    sswq_res_if res_ch ();

    sorted_sleep_wakeup_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    sswq_wake_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5ns i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ends the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("sorted_sleep_wakeup_queue_unit verification failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(t_op op, logic [ID_W-1:0] id, logic [TICKS_W-1:0] ticks);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.operation   = op;
        req_ch.waiter_id   = id;
        req_ch.sleep_ticks = ticks;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (op == OP_TICK)
            ticks_sent++;
        else
            sleeps_sent++;
    endtask

    initial begin
        int sent;
        int n;
        logic [TICKS_W-1:0] span;

        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_SLEEP;
        req_ch.waiter_id   = '0;
        req_ch.sleep_ticks = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty tick, equal wake times, extreme fields, full table
        send_item(OP_TICK, 8'h33, 32'hFFFF_FFFF);
        send_item(OP_SLEEP, 8'h00, 32'd0);
        send_item(OP_SLEEP, 8'hFF, 32'd0);
        send_item(OP_TICK, 8'h00, 32'd0);
        send_item(OP_SLEEP, 8'h5A, 32'hFFFF_FFFF);
        send_item(OP_SLEEP, 8'h01, 32'd3);
        send_item(OP_SLEEP, 8'h02, 32'd1);
        send_item(OP_SLEEP, 8'h03, 32'd3);
        for (int i = 0; i < QUEUE_DEPTH - 4; i++)
            send_item(OP_SLEEP, 8'(8'h10 + i), 32'(i % 4));
        send_item(OP_SLEEP, 8'hA5, 32'd7);
        repeat (3) send_item(OP_TICK, 8'hFF, 32'd0);

        // random: single items, sleep bursts of up to the table depth, runs of ticks
        sent = 0;
        while (sent < ITEM_GOAL) begin
            case (sent * 4 / ITEM_GOAL)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_item(OP_TICK, 8'($urandom), $urandom);
                    end else begin
                        // a couple of huge sleeps only: they never leave the table
                        if (long_sleeps < 2 && $urandom_range(0, 63) == 0) begin
                            long_sleeps++;
                            span = $urandom;
                        end else begin
                            span = $urandom_range(0, 10);
                        end
                        send_item(OP_SLEEP, 8'($urandom), span);
                    end
                    sent++;
                end
                6, 7: begin
                    n = $urandom_range(2, QUEUE_DEPTH);
                    repeat (n) send_item(OP_SLEEP, 8'($urandom), $urandom_range(0, 1));
                    repeat (2) send_item(OP_TICK, 8'($urandom), $urandom);
                    sent += n + 2;
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_item(OP_TICK, 8'($urandom), $urandom);
                    sent += n;
                end
            endcase
        end
        req_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("stimulus: %0d sleep requests and %0d ticks under four idle/stall mixes",
                 sleeps_sent, ticks_sent);
        $display("results checked: %0d, mismatches: %0d", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("sorted_sleep_wakeup_queue_unit verification clean");
        else
            $display("sorted_sleep_wakeup_queue_unit verification failed");
        $finish;
    end

endmodule
